FILE: rtl/core/wvn_pkg.sv
// ----------------------------------------------------------------------------
// wvn_pkg
// Shared types and constants of the wind value-noise grid evaluator.
// ----------------------------------------------------------------------------
package wvn_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_NOISE_SEED = 3'd0,
    REG_WIND_SCALE = 3'd1,
    REG_LON_MIN    = 3'd2,
    REG_LON_MAX    = 3'd3,
    REG_LAT_MIN    = 3'd4,
    REG_LAT_MAX    = 3'd5,
    REG_GRID_COLS  = 3'd6,
    REG_GRID_ROWS  = 3'd7
  } cfg_reg_e;

  // Queue status between the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  localparam logic [31:0] HASH_MUL_X = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
  localparam logic [31:0] MIX_MUL_A  = 32'h7feb352d;
  localparam logic [31:0] MIX_MUL_B  = 32'h846ca68b;
  localparam logic [31:0] SEED_STEP  = 32'd91;

  // Hash input offsets of the four lattice corners: (0,0), (1,0), (0,1), (1,1).
  localparam logic [31:0] CORNER_OFS [4] = '{
    32'd0, HASH_MUL_X, HASH_MUL_Y, HASH_MUL_X + HASH_MUL_Y
  };

  localparam logic [17:0] SMOOTH_K   = 18'd196608;
  localparam logic [16:0] WIND_DEN   = 17'd65535;
  localparam logic [31:0] WIND_HALF  = 32'd32767;

endpackage

FILE: rtl/core/wind_value_noise_grid_top.sv
// ----------------------------------------------------------------------------
// wind_value_noise_grid_top
// Grid node to wind vector: linear node mapping and two bilinear value-noise
// evaluations turned into east and north wind components.
//
//   Channel | Direction | Handshake              | Beat payload
//   --------+-----------+------------------------+-----------------------------------
//   in      | input     | in_valid_i/in_stall_o  | node_col_i, node_row_i
//   out     | output    | out_valid_o/out_stall_i| cell_index_o, wind_east_o/_north_o
//   cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One node is taken per cycle while in_stall_o is low. The path is MAG_W+3
// front stages (the one-bit-per-stage coordinate divider), one queue entry and
// 12 back stages: 57 register stages with the default parameters. Reset is
// asynchronous and clears the control state and the configuration to its
// defaults. A stall on the output holds the back; the front keeps taking nodes
// until the four-entry queue fills.
// ----------------------------------------------------------------------------
module wind_value_noise_grid_top import wvn_pkg::*; #(
  parameter int MAX_GRID_DIM    = 4096,
  parameter int COORD_FRAC_BITS = 20
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [$clog2(MAX_GRID_DIM)-1:0]        node_col_i,
  input  logic [$clog2(MAX_GRID_DIM)-1:0]        node_row_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [2*$clog2(MAX_GRID_DIM)-1:0]      cell_index_o,
  output logic signed [16:0]                     wind_east_o,
  output logic signed [16:0]                     wind_north_o,
  input  logic                                   cfg_we_i,
  input  logic [2:0]                             cfg_idx_i,
  input  logic [((COORD_FRAC_BITS + 9 > 32) ? COORD_FRAC_BITS + 9 : 32)-1:0] cfg_data_i
);

  localparam int IDX_W = $clog2(MAX_GRID_DIM);
  localparam int DIM_W = IDX_W + 1;
  localparam int CI_W  = 2 * IDX_W;
  localparam int LON_W = COORD_FRAC_BITS + 9;
  localparam int LAT_W = COORD_FRAC_BITS + 8;
  localparam int MAG_W = LON_W + IDX_W;
  localparam int CRD_W = MAG_W + 2;
  localparam int QW    = 2 * CRD_W + CI_W;

  localparam longint ONE_DEG = longint'(1) << COORD_FRAC_BITS;
  localparam longint OFF_LON = (173 * ONE_DEG + 5) / 10;
  localparam longint OFF_LAT = (91 * ONE_DEG + 5) / 10;
  localparam logic signed [LON_W-1:0] LON_MIN_RST = LON_W'(-180 * ONE_DEG);
  localparam logic signed [LON_W-1:0] LON_MAX_RST = LON_W'(180 * ONE_DEG);
  localparam logic signed [LAT_W-1:0] LAT_MIN_RST = LAT_W'(-90 * ONE_DEG);
  localparam logic signed [LAT_W-1:0] LAT_MAX_RST = LAT_W'(90 * ONE_DEG);

  logic        [31:0]      seed_q;
  logic        [15:0]      scale_q;
  logic signed [LON_W-1:0] lon_min_q, lon_max_q;
  logic signed [LAT_W-1:0] lat_min_q, lat_max_q;
  logic        [DIM_W-1:0] cols_q, rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q    <= '0;
      scale_q   <= 16'd256;
      lon_min_q <= LON_MIN_RST;
      lon_max_q <= LON_MAX_RST;
      lat_min_q <= LAT_MIN_RST;
      lat_max_q <= LAT_MAX_RST;
      cols_q    <= DIM_W'(1);
      rows_q    <= DIM_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NOISE_SEED: seed_q    <= cfg_data_i[31:0];
        REG_WIND_SCALE: scale_q   <= cfg_data_i[15:0];
        REG_LON_MIN:    lon_min_q <= cfg_data_i[LON_W-1:0];
        REG_LON_MAX:    lon_max_q <= cfg_data_i[LON_W-1:0];
        REG_LAT_MIN:    lat_min_q <= cfg_data_i[LAT_W-1:0];
        REG_LAT_MAX:    lat_max_q <= cfg_data_i[LAT_W-1:0];
        REG_GRID_COLS:  cols_q    <= cfg_data_i[DIM_W-1:0];
        REG_GRID_ROWS:  rows_q    <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic                    f_valid, f_en, q_push, q_pop;
  logic signed [CRD_W-1:0] f_lon, f_lat;
  logic        [CI_W-1:0]  f_cell;
  logic        [QW-1:0]    q_head;
  qstat_t                  q_stat;

  // The front stalls only when its finished node cannot enter the queue.
  assign f_en       = !(f_valid && q_stat.full);
  assign in_stall_o = !f_en;
  assign q_push     = f_valid && !q_stat.full;

  wvn_front #(
    .LON_W(LON_W), .LAT_W(LAT_W), .IDX_W(IDX_W), .DIM_W(DIM_W),
    .MAG_W(MAG_W), .CRD_W(CRD_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (f_en),
    .in_valid_i (in_valid_i),
    .node_col_i (node_col_i),
    .node_row_i (node_row_i),
    .lon_min_i  (lon_min_q),
    .lon_max_i  (lon_max_q),
    .lat_min_i  (lat_min_q),
    .lat_max_i  (lat_max_q),
    .grid_cols_i(cols_q),
    .grid_rows_i(rows_q),
    .valid_o    (f_valid),
    .lon_o      (f_lon),
    .lat_o      (f_lat),
    .cell_o     (f_cell)
  );

  wvn_fifo #(.W(QW)) u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(q_push),
    .data_i({f_lon, f_lat, f_cell}),
    .pop_i (q_pop),
    .data_o(q_head),
    .stat_o(q_stat)
  );

  wvn_back #(
    .CRD_W(CRD_W), .FRAC_W(COORD_FRAC_BITS), .CI_W(CI_W),
    .OFF_LON(OFF_LON), .OFF_LAT(OFF_LAT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(!q_stat.empty),
    .lon_i       (q_head[QW-1 -: CRD_W]),
    .lat_i       (q_head[CI_W +: CRD_W]),
    .cell_i      (q_head[CI_W-1:0]),
    .seed_i      (seed_q),
    .scale_i     (scale_q),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cell_index_o(cell_index_o),
    .wind_east_o (wind_east_o),
    .wind_north_o(wind_north_o)
  );

endmodule

FILE: rtl/core/wvn_axis.sv
// ----------------------------------------------------------------------------
// wvn_axis
// Maps a node index onto one coordinate axis: lo + floor((hi-lo)*idx/(n-1)),
// with a pipelined restoring divider that resolves one quotient bit a stage.
// ----------------------------------------------------------------------------
module wvn_axis #(
  parameter int CO_W  = 29,
  parameter int IDX_W = 12,
  parameter int DIM_W = 13,
  parameter int MAG_W = 41,
  parameter int CRD_W = 43
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic        [IDX_W-1:0] idx_i,
  input  logic signed [CO_W-1:0]  lo_i,
  input  logic signed [CO_W-1:0]  hi_i,
  input  logic        [DIM_W-1:0] dim_i,
  output logic signed [CRD_W-1:0] coord_o
);

  localparam int PW = CO_W + IDX_W + 2;
  localparam int AW = DIM_W + 1 + MAG_W;

  logic signed [PW-1:0]     prod_d, prod_q;
  logic                     neg_b_d;
  logic        [PW-1:0]     mag_full;
  logic        [DIM_W-1:0]  den;
  logic        [AW-1:0]     acc_q [MAG_W+1];
  logic                     neg_q [MAG_W+1];
  logic        [MAG_W-1:0]  quo;
  logic                     rem_nz;
  logic signed [CRD_W-1:0]  q_s, rem_s, delta, coord_d;

  assign prod_d  = (hi_i - lo_i) * $signed({1'b0, idx_i});
  assign neg_b_d = prod_q[PW-1];
  assign mag_full = neg_b_d ? PW'(-prod_q) : PW'(prod_q);
  assign den     = dim_i - DIM_W'(1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= prod_d;
      acc_q[0] <= {{(DIM_W + 1){1'b0}}, mag_full[MAG_W-1:0]};
      neg_q[0] <= neg_b_d;
    end
  end

  // One quotient bit per stage: shift in the next dividend bit, subtract if it fits.
  for (genvar k = 1; k <= MAG_W; k++) begin : g_div
    logic [AW-1:0]    sh;
    logic [DIM_W:0]   top;
    logic [AW-1:0]    acc_d;
    always_comb begin
      sh    = {acc_q[k-1][AW-2:0], 1'b0};
      top   = sh[AW-1:MAG_W];
      acc_d = sh;
      if (top >= {1'b0, den}) begin
        acc_d[AW-1:MAG_W] = top - {1'b0, den};
        acc_d[0]          = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[k] <= acc_d;
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  assign quo    = acc_q[MAG_W][MAG_W-1:0];
  assign rem_nz = |acc_q[MAG_W][AW-1:MAG_W];
  assign q_s    = $signed({2'b00, quo});
  assign rem_s  = $signed({{(CRD_W - 1){1'b0}}, rem_nz});

  // A negative dividend with a remainder rounds one further toward minus infinity.
  assign delta   = neg_q[MAG_W] ? (-q_s - rem_s) : q_s;
  assign coord_d = (dim_i <= DIM_W'(1)) ? CRD_W'(lo_i) : (CRD_W'(lo_i) + delta);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      coord_o <= coord_d;
    end
  end

endmodule

FILE: rtl/core/wvn_front.sv
// ----------------------------------------------------------------------------
// wvn_front
// Accepts grid nodes, forms the row-major cell index and maps the node onto
// longitude and latitude.
// ----------------------------------------------------------------------------
module wvn_front #(
  parameter int LON_W = 29,
  parameter int LAT_W = 28,
  parameter int IDX_W = 12,
  parameter int DIM_W = 13,
  parameter int MAG_W = 41,
  parameter int CRD_W = 43
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      in_valid_i,
  input  logic        [IDX_W-1:0]   node_col_i,
  input  logic        [IDX_W-1:0]   node_row_i,
  input  logic signed [LON_W-1:0]   lon_min_i,
  input  logic signed [LON_W-1:0]   lon_max_i,
  input  logic signed [LAT_W-1:0]   lat_min_i,
  input  logic signed [LAT_W-1:0]   lat_max_i,
  input  logic        [DIM_W-1:0]   grid_cols_i,
  input  logic        [DIM_W-1:0]   grid_rows_i,
  output logic                      valid_o,
  output logic signed [CRD_W-1:0]   lon_o,
  output logic signed [CRD_W-1:0]   lat_o,
  output logic        [2*IDX_W-1:0] cell_o
);

  localparam int LAT_N = MAG_W + 3;
  localparam int CI_W  = 2 * IDX_W;

  logic [LAT_N-1:0] vld_q;
  logic [CI_W-1:0]  cell_q [LAT_N];
  logic [CI_W:0]    cell_full;

  assign cell_full = (CI_W + 1)'(node_row_i) * (CI_W + 1)'(grid_cols_i)
                   + (CI_W + 1)'(node_col_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[LAT_N-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q[0] <= cell_full[CI_W-1:0];
      for (int i = 1; i < LAT_N; i++) begin
        cell_q[i] <= cell_q[i-1];
      end
    end
  end

  wvn_axis #(
    .CO_W (LON_W), .IDX_W(IDX_W), .DIM_W(DIM_W), .MAG_W(MAG_W), .CRD_W(CRD_W)
  ) u_lon (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .idx_i  (node_col_i),
    .lo_i   (lon_min_i),
    .hi_i   (lon_max_i),
    .dim_i  (grid_cols_i),
    .coord_o(lon_o)
  );

  wvn_axis #(
    .CO_W (LAT_W), .IDX_W(IDX_W), .DIM_W(DIM_W), .MAG_W(MAG_W), .CRD_W(CRD_W)
  ) u_lat (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .idx_i  (node_row_i),
    .lo_i   (lat_min_i),
    .hi_i   (lat_max_i),
    .dim_i  (grid_rows_i),
    .coord_o(lat_o)
  );

  assign valid_o = vld_q[LAT_N-1];
  assign cell_o  = cell_q[LAT_N-1];

endmodule

FILE: rtl/core/wvn_fifo.sv
// ----------------------------------------------------------------------------
// wvn_fifo
// Four-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module wvn_fifo import wvn_pkg::*; #(
  parameter int W = 110
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output qstat_t       stat_o
);

  logic [W-1:0] mem_q [4];
  logic [1:0]   wr_q, rd_q;
  logic [2:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 2'd1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 2'd1;
      end
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == 3'd4);
  assign stat_o.empty = (cnt_q == 3'd0);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty) else $error("queue read while empty");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 3'd1)
    else $error("queue count lost a write");

endmodule

FILE: rtl/core/wvn_noise.sv
// ----------------------------------------------------------------------------
// wvn_noise
// Bilinear value noise at four cells per degree: lattice split, corner
// hashes, smoothstep weights and blend, nine register stages.
// ----------------------------------------------------------------------------
module wvn_noise import wvn_pkg::*; #(
  parameter int     CRD_W  = 43,
  parameter int     FRAC_W = 20,
  parameter longint OFS_X  = 0,
  parameter longint OFS_Y  = 0
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [CRD_W-1:0] lon_i,
  input  logic signed [CRD_W-1:0] lat_i,
  input  logic        [31:0]      seed_i,
  output logic        [15:0]      n16_o
);

  localparam int XW = CRD_W + 1;
  localparam int SH = FRAC_W - 2;

  logic signed [XW-1:0] x_q, y_q, xs, ys;
  logic [31:0] cx_q, cy_q, px_q, py_q, ffx_q, ffy_q;
  logic [15:0] fx_q, fy_q;
  logic [17:0] wx_q, wy_q;
  logic [49:0] smx, smy;
  logic [16:0] sx_q [3:5];
  logic [16:0] sy_q [3:6];
  logic [31:0] base;
  logic [31:0] t_q  [4];
  logic [31:0] m1_q [4];
  logic [31:0] m2_q [4];
  logic [15:0] h    [4];
  logic signed [16:0] dab, dcd;
  logic signed [35:0] tab, tcd;
  logic [31:0] ab_q, cd_q;
  logic signed [32:0] dn;
  logic signed [51:0] tn;
  logic [47:0] n_q;
  logic [48:0] nr;

  assign xs = x_q >>> SH;
  assign ys = y_q >>> SH;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Stage 0: position offset.
      x_q   <= XW'(lon_i) + XW'(OFS_X);
      y_q   <= XW'(lat_i) + XW'(OFS_Y);
      // Stage 1: lattice cell and Q0.16 fraction.
      cx_q  <= 32'(xs);
      cy_q  <= 32'(ys);
      fx_q  <= 16'({x_q, 16'b0} >> SH);
      fy_q  <= 16'({y_q, 16'b0} >> SH);
      // Stage 2: corner products and smoothstep square.
      px_q  <= cx_q * HASH_MUL_X;
      py_q  <= cy_q * HASH_MUL_Y;
      ffx_q <= {16'b0, fx_q} * {16'b0, fx_q};
      ffy_q <= {16'b0, fy_q} * {16'b0, fy_q};
      wx_q  <= SMOOTH_K - {1'b0, fx_q, 1'b0};
      wy_q  <= SMOOTH_K - {1'b0, fy_q, 1'b0};
      // Stage 3: smoothstep weights.
      sx_q[3] <= smx[48:32];
      sy_q[3] <= smy[48:32];
      for (int i = 4; i <= 5; i++) begin
        sx_q[i] <= sx_q[i-1];
      end
      for (int i = 4; i <= 6; i++) begin
        sy_q[i] <= sy_q[i-1];
      end
      // Stage 6: horizontal blends, stage 7: vertical blend, stage 8: rounding.
      ab_q  <= tab[31:0];
      cd_q  <= tcd[31:0];
      n_q   <= tn[47:0];
      n16_o <= nr[47:32];
    end
  end

  assign smx  = {18'b0, ffx_q} * {32'b0, wx_q};
  assign smy  = {18'b0, ffy_q} * {32'b0, wy_q};
  assign base = px_q + py_q + seed_i;

  for (genvar l = 0; l < 4; l++) begin : g_corner
    logic [31:0] h1, h2;
    assign h1 = t_q[l] ^ (t_q[l] >> 16);
    assign h2 = m1_q[l] ^ (m1_q[l] >> 15);
    assign h[l] = m2_q[l][15:0] ^ m2_q[l][31:16];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t_q[l]  <= base + CORNER_OFS[l];
        m1_q[l] <= h1 * MIX_MUL_A;
        m2_q[l] <= h2 * MIX_MUL_B;
      end
    end
  end

  // a*(1-s) + b*s is written as a + (b-a)*s to keep one multiplier per blend.
  assign dab = $signed({1'b0, h[1]}) - $signed({1'b0, h[0]});
  assign dcd = $signed({1'b0, h[3]}) - $signed({1'b0, h[2]});
  assign tab = $signed({4'b0, h[0], 16'b0}) + dab * $signed({1'b0, sx_q[5]});
  assign tcd = $signed({4'b0, h[2], 16'b0}) + dcd * $signed({1'b0, sx_q[5]});
  assign dn  = $signed({1'b0, cd_q}) - $signed({1'b0, ab_q});
  assign tn  = $signed({4'b0, ab_q, 16'b0}) + dn * $signed({1'b0, sy_q[6]});
  assign nr  = {1'b0, n_q} + 49'h0_8000_0000;

endmodule

FILE: rtl/core/wvn_back.sv
// ----------------------------------------------------------------------------
// wvn_back
// Evaluates the two noise values of a node and scales them into wind
// components; the last stage is the output register.
// ----------------------------------------------------------------------------
module wvn_back import wvn_pkg::*; #(
  parameter int     CRD_W   = 43,
  parameter int     FRAC_W  = 20,
  parameter int     CI_W    = 24,
  parameter longint OFF_LON = 0,
  parameter longint OFF_LAT = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    head_valid_i,
  input  logic signed [CRD_W-1:0] lon_i,
  input  logic signed [CRD_W-1:0] lat_i,
  input  logic        [CI_W-1:0]  cell_i,
  input  logic        [31:0]      seed_i,
  input  logic        [15:0]      scale_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic        [CI_W-1:0]  cell_index_o,
  output logic signed [16:0]      wind_east_o,
  output logic signed [16:0]      wind_north_o
);

  localparam int LAT_N = 12;

  logic              en;
  logic [LAT_N-1:0]  vld_q;
  logic [CI_W-1:0]   cell_q [LAT_N];
  logic [15:0]       n16 [2];
  logic signed [16:0] wind [2];
  logic [31:0]       seed2;

  assign en    = !(out_valid_o && out_stall_i);
  assign pop_o = en && head_valid_i;
  assign seed2 = seed_i + SEED_STEP;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT_N-2:0], head_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cell_q[0] <= cell_i;
      for (int i = 1; i < LAT_N; i++) begin
        cell_q[i] <= cell_q[i-1];
      end
    end
  end

  wvn_noise #(.CRD_W(CRD_W), .FRAC_W(FRAC_W), .OFS_X(0), .OFS_Y(0)) u_noise_e (
    .clk_i (clk_i),
    .en_i  (en),
    .lon_i (lon_i),
    .lat_i (lat_i),
    .seed_i(seed_i),
    .n16_o (n16[0])
  );

  wvn_noise #(.CRD_W(CRD_W), .FRAC_W(FRAC_W), .OFS_X(OFF_LON), .OFS_Y(-OFF_LAT)) u_noise_n (
    .clk_i (clk_i),
    .en_i  (en),
    .lon_i (lon_i),
    .lat_i (lat_i),
    .seed_i(seed2),
    .n16_o (n16[1])
  );

  // Wind = (2n-65535)*scale/65535, rounded half away from zero. The divide by
  // 65535 uses x = q0*65535 + (lo16 + q0) and at most two corrections.
  for (genvar l = 0; l < 2; l++) begin : g_wind
    logic signed [17:0] v;
    logic signed [34:0] num_d, num_q;
    logic        [34:0] mag;
    logic        [31:0] x;
    logic        [15:0] q0_q;
    logic        [16:0] r_d, r_q, r1;
    logic               neg_q, c1, c2;
    logic        [16:0] q;

    assign v     = $signed({1'b0, n16[l], 1'b0}) - 18'sd65535;
    assign num_d = v * $signed({1'b0, scale_i});
    assign mag   = num_q[34] ? 35'(-num_q) : 35'(num_q);
    assign x     = mag[31:0] + WIND_HALF;
    assign r_d   = {1'b0, x[15:0]} + {1'b0, x[31:16]};
    assign c1    = (r_q >= WIND_DEN);
    assign r1    = c1 ? (r_q - WIND_DEN) : r_q;
    assign c2    = (r1 >= WIND_DEN);
    assign q     = {1'b0, q0_q} + 17'(c1) + 17'(c2);

    always_ff @(posedge clk_i) begin
      if (en) begin
        num_q   <= num_d;
        neg_q   <= num_q[34];
        q0_q    <= x[31:16];
        r_q     <= r_d;
        wind[l] <= neg_q ? -$signed(q) : $signed(q);
      end
    end
  end

  assign out_valid_o  = vld_q[LAT_N-1];
  assign cell_index_o = cell_q[LAT_N-1];
  assign wind_east_o  = wind[0];
  assign wind_north_o = wind[1];

endmodule
